// ----- hw/rtl/tqsa_pkg.sv -----
`default_nettype none
package tqsa_pkg;

  // Store geometry
  localparam int DEPTH = 16;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = AW + 1;

  // Operation codes
  localparam logic [1:0] OP_ENQ_A = 2'd0;
  localparam logic [1:0] OP_ENQ_B = 2'd1;
  localparam logic [1:0] OP_DEQ_A = 2'd2;
  localparam logic [1:0] OP_DEQ_B = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic load;     // latch the input beat
    logic exec;     // update pointers, write or read the store
    logic capture;  // move read data into the result register
  } tqsa_cmd_t;

  typedef struct packed {
    logic need_read;  // latched operation is a dequeue on a non-empty queue
  } tqsa_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/two_queues_shared_array.sv -----
// Two queues in one shared store.
// Queue A grows upward from slot 0, queue B downward from the top slot.
// Input channel (in_valid/in_ready): one beat carries operation
//   (enqueue A, enqueue B, dequeue A, dequeue B) and push_value.
// Output channel (out_valid/out_ready): one result beat per input beat,
//   carrying status (ok, overflow, underflow) and popped_value
//   (the dequeued word, zero otherwise).
// Sequence: after the input beat the controller passes through EXEC (pointer
//   update, store write, registered read of the store), then READ for
//   successful dequeues only (read data into the result register), then
//   DONE, where out_valid is high until the result beat is taken.
// The block works on one item at a time; while the receiver keeps out_ready
//   high, the next input beat is taken in the same cycle the result is taken.
// A stalled receiver holds the result and blocks new input beats.
// Reset (rst, synchronous) empties both queues and the controller; the store
//   contents are not cleared, since no slot is read before it is written.
`default_nettype none
module two_queues_shared_array (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire [1:0]          operation,
  input  wire signed [31:0]  push_value,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] popped_value
);
  import tqsa_pkg::*;

  tqsa_cmd_t  cmd;
  tqsa_stat_t stat;

  // Sequence each beat: latch, execute, optional read capture, hold result
  tqsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Pointers, shared store and result register
  tqsa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .push_value   (push_value),
    .status       (status),
    .popped_value (popped_value)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/tqsa_ctrl.sv -----
`default_nettype none
module tqsa_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  tqsa_pkg::tqsa_stat_t stat,
  output tqsa_pkg::tqsa_cmd_t  cmd
);
  import tqsa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.need_read ? S_READ : S_DONE;
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = S_EXEC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tqsa_dp.sv -----
`default_nettype none
module tqsa_dp (
  input  wire                  clk,
  input  wire                  rst,
  input  tqsa_pkg::tqsa_cmd_t  cmd,
  output tqsa_pkg::tqsa_stat_t stat,
  input  wire [1:0]            operation,
  input  wire signed [31:0]    push_value,
  output logic [1:0]           status,
  output logic signed [31:0]   popped_value
);
  import tqsa_pkg::*;

  localparam logic [AW-1:0] TOP = AW'(DEPTH - 1);

  logic signed [31:0] store [DEPTH];
  logic signed [31:0] rd_data;

  logic [1:0]         op;
  logic signed [31:0] val;

  logic [AW-1:0] a_head;
  logic [AW-1:0] a_tail;
  logic          a_empty;
  logic [AW-1:0] b_head;
  logic [AW-1:0] b_tail;
  logic          b_empty;

  logic [PW-1:0] a_next;
  logic [PW-1:0] b_last;
  logic          full;
  logic [AW-1:0] b_wr_idx;
  logic [AW-1:0] rd_idx;

  always_comb begin
    a_next   = a_empty ? '0 : {1'b0, a_tail} + PW'(1);
    b_last   = b_empty ? PW'(DEPTH) : {1'b0, b_tail};
    full     = (a_next >= b_last);
    b_wr_idx = b_empty ? TOP : b_tail - AW'(1);
    rd_idx   = (op == OP_DEQ_A) ? a_head : b_head;
    stat.need_read = ((op == OP_DEQ_A) && !a_empty) || ((op == OP_DEQ_B) && !b_empty);
  end

  // Input latch and store port
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= operation;
      val <= push_value;
    end
    if (cmd.exec) begin
      rd_data <= store[rd_idx];
      if (!full && op == OP_ENQ_A) begin
        store[a_next[AW-1:0]] <= val;
      end
      if (!full && op == OP_ENQ_B) begin
        store[b_wr_idx] <= val;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      popped_value <= '0;
      case (op)
        OP_ENQ_A, OP_ENQ_B: status <= full ? ST_OVERFLOW : ST_OK;
        OP_DEQ_A:           status <= a_empty ? ST_UNDERFLOW : ST_OK;
        OP_DEQ_B:           status <= b_empty ? ST_UNDERFLOW : ST_OK;
        default:            status <= ST_OK;
      endcase
    end
    if (cmd.capture) begin
      popped_value <= rd_data;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_head  <= '0;
      a_tail  <= '0;
      a_empty <= 1'b1;
      b_head  <= TOP;
      b_tail  <= TOP;
      b_empty <= 1'b1;
    end else if (cmd.exec) begin
      case (op)
        OP_ENQ_A: begin
          if (!full) begin
            if (a_empty) begin
              a_head <= '0;
            end
            a_empty <= 1'b0;
            a_tail  <= a_next[AW-1:0];
          end
        end
        OP_ENQ_B: begin
          if (!full) begin
            if (b_empty) begin
              b_head <= TOP;
            end
            b_empty <= 1'b0;
            b_tail  <= b_wr_idx;
          end
        end
        OP_DEQ_A: begin
          if (!a_empty) begin
            if (a_head >= a_tail) begin
              a_head  <= '0;
              a_tail  <= '0;
              a_empty <= 1'b1;
            end else begin
              a_head <= a_head + AW'(1);
            end
          end
        end
        OP_DEQ_B: begin
          if (!b_empty) begin
            if (b_head <= b_tail) begin
              b_head  <= TOP;
              b_tail  <= TOP;
              b_empty <= 1'b1;
            end else begin
              b_head <= b_head - AW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
module testbench;
  import tqsa_pkg::*;

  localparam int CYCLE_LIMIT  = 800_000;
  localparam int RANDOM_ITEMS = 1875;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 400;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] popped;
  } result_t;

  // One line of the directed table; want is only used when typed is set.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
    logic        typed;
    result_t     want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [1:0] operation = OP_ENQ_A;
  logic signed [31:0] push_value = '0;
  logic out_ready = 1'b0;
  wire in_ready;
  wire out_valid;
  wire [1:0] status;
  wire signed [31:0] popped_value;

  two_queues_shared_array dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .push_value   (push_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .popped_value (popped_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the shared store and of both queues' pointers. Pointers carry one
  // extra bit so that "one past the top" (B empty) fits.
  logic [31:0]   slot_mirror [DEPTH];
  logic [PW-1:0] a_head_m, a_tail_m, b_head_m, b_tail_m;
  logic          a_empty_m, b_empty_m;

  result_t   pending_results [$];
  stim_row_t directed [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        items_sent = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  int        steady_left = 0;
  logic      hold_off = 1'b0;

  // Apply one operation to the mirrored queues and return the result it gives.
  function automatic result_t apply_queue_op(input logic [1:0] op, input logic [31:0] val);
    logic [PW-1:0] a_next;
    logic [PW-1:0] b_last;
    result_t       r;
    r.status = ST_OK;
    r.popped = '0;
    // Next slot A would take, and the lowest slot B holds (top+1 while B is empty).
    a_next = a_empty_m ? '0 : a_tail_m + 1'b1;
    b_last = b_empty_m ? PW'(DEPTH) : b_tail_m;
    case (op)
      OP_ENQ_A, OP_ENQ_B: begin
        if (a_next >= b_last) begin
          r.status = ST_OVERFLOW;
        end else if (op == OP_ENQ_A) begin
          a_empty_m = 1'b0;
          a_tail_m = a_next;
          slot_mirror[a_tail_m[AW-1:0]] = val;
        end else begin
          if (b_empty_m) begin
            b_tail_m = PW'(DEPTH - 1);
            b_empty_m = 1'b0;
          end else begin
            b_tail_m = b_last - 1'b1;
          end
          slot_mirror[b_tail_m[AW-1:0]] = val;
        end
      end
      OP_DEQ_A: begin
        if (a_empty_m) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.popped = slot_mirror[a_head_m[AW-1:0]];
          // Last item out: snap A back to slot 0 so its slots are reused.
          if (a_head_m >= a_tail_m) begin
            a_head_m = '0;
            a_tail_m = '0;
            a_empty_m = 1'b1;
          end else begin
            a_head_m = a_head_m + 1'b1;
          end
        end
      end
      OP_DEQ_B: begin
        if (b_empty_m) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.popped = slot_mirror[b_head_m[AW-1:0]];
          if (b_head_m <= b_tail_m) begin
            b_head_m = PW'(DEPTH - 1);
            b_tail_m = PW'(DEPTH - 1);
            b_empty_m = 1'b1;
          end else begin
            b_head_m = b_head_m - 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic stim_row_t mk_row(input logic [1:0] op, input logic [31:0] val,
                                       input logic typed, input logic [1:0] st,
                                       input logic [31:0] pv);
    stim_row_t row;
    row.op = op;
    row.value = val;
    row.typed = typed;
    row.want.status = st;
    row.want.popped = pv;
    return row;
  endfunction

  // Mostly back-to-back, sometimes a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random word, with the corner values mixed in about one time in eight.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 7) != 0) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  // mode: 0 fill-heavy, 1 drain-heavy, 2 even. side: 0 both queues, 1 only A, 2 only B.
  function automatic logic [1:0] pick_op(input int mode, input int side);
    logic is_enq;
    logic is_b;
    case (mode)
      0: is_enq = ($urandom_range(0, 3) != 0);
      1: is_enq = ($urandom_range(0, 3) == 0);
      default: is_enq = 1'($urandom_range(0, 1));
    endcase
    case (side)
      1: is_b = 1'b0;
      2: is_b = 1'b1;
      default: is_b = 1'($urandom_range(0, 1));
    endcase
    if (is_enq) return is_b ? OP_ENQ_B : OP_ENQ_A;
    return is_b ? OP_DEQ_B : OP_DEQ_A;
  endfunction

  task automatic log_fail(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // Offer one beat after an optional idle gap, hold it until taken, then
  // record what the block owes for it.
  task automatic send_beat(input logic [1:0] op, input logic [31:0] val, input int gap,
                           input logic typed, input result_t want);
    result_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    push_value <= val;
    do @(posedge clk); while (!in_ready);
    predicted = apply_queue_op(op, val);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Receiver: random stalls, stretches of steady ready, and the long hold-off
  // window that backs results up into the input side.
  always @(posedge clk) begin
    int r;
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (steady_left > 0) begin
      out_ready <= 1'b1;
      steady_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        steady_left = $urandom_range(30, 150);
        out_ready <= 1'b1;
      end else if (r < 65) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_ready <= 1'b0;
      end
    end
  end

  // Hold off the receiver once, mid-run, while the sender keeps offering beats.
  initial begin
    wait (items_sent >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Compare every result beat, field by field, against the oldest expectation.
  always @(posedge clk) begin
    result_t want_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        log_fail($sformatf("result %0d: arrived with nothing expected (status %0d, value %h)",
                           results_seen, status, popped_value));
      end else begin
        want_r = pending_results.pop_front();
        if (status !== want_r.status)
          log_fail($sformatf("result %0d: status expected %0d, got %0d",
                             results_seen, want_r.status, status));
        if (popped_value !== want_r.popped)
          log_fail($sformatf("result %0d: popped_value expected %h, got %h",
                             results_seen, want_r.popped, popped_value));
      end
    end
  end

  // Watchdog: give up if the run stalls.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int mode;
    int side;
    int burst_len;
    logic quiet;
    result_t no_want;

    no_want = '0;
    foreach (slot_mirror[i]) slot_mirror[i] = '0;
    a_head_m = '0;
    a_tail_m = '0;
    a_empty_m = 1'b1;
    b_head_m = PW'(DEPTH - 1);
    b_tail_m = PW'(DEPTH - 1);
    b_empty_m = 1'b1;

    // Directed table: underflow on both empty queues, extreme values through
    // each queue, the emptied queue underflowing again, then both queues filled
    // until they meet in the middle and overflow from either side.
    directed.push_back(mk_row(OP_DEQ_A, 32'h0, 1'b1, ST_UNDERFLOW, 32'h0));
    directed.push_back(mk_row(OP_DEQ_B, 32'h0, 1'b1, ST_UNDERFLOW, 32'h0));
    directed.push_back(mk_row(OP_ENQ_A, 32'h7FFF_FFFF, 1'b1, ST_OK, 32'h0));
    directed.push_back(mk_row(OP_ENQ_B, 32'h8000_0000, 1'b1, ST_OK, 32'h0));
    directed.push_back(mk_row(OP_DEQ_A, 32'h0, 1'b1, ST_OK, 32'h7FFF_FFFF));
    directed.push_back(mk_row(OP_DEQ_B, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h8000_0000));
    directed.push_back(mk_row(OP_DEQ_A, 32'h0, 1'b1, ST_UNDERFLOW, 32'h0));
    for (int i = 0; i < DEPTH / 2; i++) begin
      directed.push_back(mk_row(OP_ENQ_A, 32'h1111_1111 * i, 1'b0, ST_OK, 32'h0));
      directed.push_back(mk_row(OP_ENQ_B, ~(32'h1111_1111 * i), 1'b0, ST_OK, 32'h0));
    end
    directed.push_back(mk_row(OP_ENQ_A, 32'hDEAD_BEEF, 1'b1, ST_OVERFLOW, 32'h0));
    directed.push_back(mk_row(OP_ENQ_B, 32'h0BAD_F00D, 1'b1, ST_OVERFLOW, 32'h0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_beat(directed[i].op, directed[i].value, pick_gap(), directed[i].typed,
                directed[i].want);

    // Random bursts: each leans toward filling or draining, on one queue or
    // both, so the queues swing between empty, full and the meeting point.
    while (items_sent < directed.size() + RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      side = $urandom_range(0, 3);
      burst_len = $urandom_range(4, 40);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (burst_len)
        send_beat(pick_op(mode, side), pick_value(), quiet ? 0 : pick_gap(), 1'b0, no_want);
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed result, then a few cycles for strays.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
